// File: rtl/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked on every rising edge, also while reset is high.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// File: rtl/bcs_pkg.sv
package bcs_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int MS_BITS       = 26;
  localparam int MS_PER_SEC    = 1000;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_CMD  = 2'd1;
  localparam logic [1:0] REQ_BREW = 2'd2;

  localparam logic [3:0] CMD_OFF      = 4'd0;
  localparam logic [3:0] CMD_POUR     = 4'd1;
  localparam logic [3:0] CMD_STOP     = 4'd2;
  localparam logic [3:0] CMD_BOIL     = 4'd3;
  localparam logic [3:0] CMD_STEAM    = 4'd4;
  localparam logic [3:0] CMD_COOL     = 4'd5;
  localparam logic [3:0] CMD_BREW     = 4'd6;
  localparam logic [3:0] CMD_SW_BOIL  = 4'd7;
  localparam logic [3:0] CMD_SW_STEAM = 4'd8;
  localparam logic [3:0] CMD_SW_POUR  = 4'd9;

  localparam logic [1:0] SW_OFF   = 2'd0;
  localparam logic [1:0] SW_BOIL  = 2'd1;
  localparam logic [1:0] SW_STEAM = 2'd2;
  localparam logic [1:0] SW_POUR  = 2'd3;

  localparam logic [1:0] LVL_COLD  = 2'd0;
  localparam logic [1:0] LVL_BOIL  = 2'd1;
  localparam logic [1:0] LVL_STEAM = 2'd2;

  localparam logic [25:0] MS_LEFT_MAX = 26'd65535000;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_TICK,
    KIND_LOAD
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [3:0]          cmd;
    logic [MS_BITS-1:0]  ms;
    logic [1:0]          sw;
    logic                moved;
    logic [1:0]          level;
  } item_t;

endpackage

// File: rtl/bcs_front.sv
module bcs_front import bcs_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic [1:0]           req_type,
  input  logic [3:0]           cmd_code,
  input  logic [15:0]          brew_seconds,
  input  logic [1:0]           switch_pos,
  input  logic                 switch_moved,
  input  logic [1:0]           boiler_level,
  input  logic [31:0]          now_ms,
  output item_t                item,
  output logic [TIME_BITS-1:0] now_t
);

  logic [MS_BITS-1:0] brew_ms;

  assign brew_ms = MS_BITS'(brew_seconds) * MS_BITS'(MS_PER_SEC);
  assign now_t   = TIME_BITS'(now_ms);

  always_comb begin
    item.kind  = KIND_NONE;
    item.cmd   = cmd_code;
    item.ms    = '0;
    item.sw    = switch_pos;
    item.moved = switch_moved;
    item.level = boiler_level;
    case (req_type)
      REQ_TICK: item.kind = KIND_TICK;
      REQ_CMD: begin
        if (cmd_code < CMD_BREW && switch_pos == SW_OFF) begin
          item.kind = KIND_LOAD;
        end
      end
      REQ_BREW: begin
        if (cmd_code == CMD_BREW && brew_seconds != 16'd0 && switch_pos == SW_OFF) begin
          item.kind = KIND_LOAD;
          item.ms   = brew_ms;
        end
      end
      default: item.kind = KIND_NONE;
    endcase
  end

endmodule

// File: rtl/bcs_queue.sv
module bcs_queue import bcs_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/bcs_back.sv
module bcs_back import bcs_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  item_t                item,
  input  logic [TIME_BITS-1:0] now_t,
  output logic                 res_accepted,
  output logic                 res_pump,
  output logic [1:0]           res_target,
  output logic                 res_done,
  output logic [MS_BITS-1:0]   res_ms,
  output logic [3:0]           res_cmd
);

  localparam int CW = (TIME_BITS > MS_BITS) ? TIME_BITS : MS_BITS;

  logic [3:0]           current_cmd, current_cmd_next;
  logic [MS_BITS-1:0]   ms_remaining, ms_remaining_next;
  logic [TIME_BITS-1:0] pour_started_at, pour_started_at_next;
  logic                 pouring, pouring_next;
  logic                 pump_reg, pump_reg_next;
  logic [1:0]           target_reg, target_reg_next;
  logic                 done_reg, done_reg_next;

  logic [TIME_BITS-1:0] end_time;
  logic [TIME_BITS-1:0] elapsed;
  logic [CW-1:0]        elapsed_w;
  logic [CW-1:0]        ms_w;
  logic [CW-1:0]        ms_diff;
  logic [3:0]           tick_cmd;

  assign end_time  = pour_started_at + TIME_BITS'(ms_remaining);
  assign elapsed   = now_t - pour_started_at;
  assign elapsed_w = CW'(elapsed);
  assign ms_w      = CW'(ms_remaining);
  assign ms_diff   = ms_w - elapsed_w;

  always_comb begin
    case (item.sw)
      SW_BOIL:  tick_cmd = CMD_SW_BOIL;
      SW_STEAM: tick_cmd = CMD_SW_STEAM;
      SW_POUR:  tick_cmd = CMD_SW_POUR;
      default:  tick_cmd = CMD_OFF;
    endcase
  end

  always_comb begin
    current_cmd_next     = current_cmd;
    ms_remaining_next    = ms_remaining;
    pour_started_at_next = pour_started_at;
    pouring_next         = pouring;
    pump_reg_next        = pump_reg;
    target_reg_next      = target_reg;
    done_reg_next        = done_reg;

    case (item.kind)
      KIND_LOAD: begin
        current_cmd_next     = item.cmd;
        ms_remaining_next    = item.ms;
        pour_started_at_next = '0;
        pouring_next         = 1'b0;
      end
      KIND_TICK: begin
        if (item.moved) begin
          current_cmd_next = tick_cmd;
        end
        case (current_cmd_next)
          CMD_POUR:  pump_reg_next = 1'b1;
          CMD_STOP:  pump_reg_next = 1'b0;
          CMD_BOIL:  target_reg_next = LVL_BOIL;
          CMD_STEAM: target_reg_next = LVL_STEAM;
          CMD_COOL:  target_reg_next = LVL_COLD;
          CMD_BREW: begin
            if (ms_remaining == '0) begin
              pump_reg_next   = 1'b0;
              target_reg_next = LVL_COLD;
            end else if (!pouring) begin
              // Heat first; pouring starts once the boiler reports boiling.
              target_reg_next = LVL_BOIL;
              if (item.level == LVL_BOIL) begin
                pump_reg_next        = 1'b1;
                pour_started_at_next = now_t;
                pouring_next         = 1'b1;
              end
            end else if (end_time >= now_t) begin
              // Boiler dropped out of boiling: pause and keep the time left.
              if (item.level != LVL_BOIL) begin
                pump_reg_next        = 1'b0;
                ms_remaining_next    = (elapsed_w >= ms_w) ? '0 : MS_BITS'(ms_diff);
                pour_started_at_next = '0;
                pouring_next         = 1'b0;
              end
            end else begin
              pump_reg_next        = 1'b0;
              target_reg_next      = LVL_COLD;
              ms_remaining_next    = '0;
              pour_started_at_next = '0;
              pouring_next         = 1'b0;
            end
          end
          CMD_SW_BOIL: begin
            pump_reg_next   = 1'b0;
            target_reg_next = LVL_BOIL;
          end
          CMD_SW_STEAM: begin
            pump_reg_next   = 1'b0;
            target_reg_next = LVL_STEAM;
          end
          CMD_SW_POUR: begin
            pump_reg_next   = 1'b1;
            target_reg_next = LVL_COLD;
          end
          default: begin
            pump_reg_next   = 1'b0;
            target_reg_next = LVL_COLD;
          end
        endcase
        if (current_cmd_next == CMD_BREW) begin
          done_reg_next = (ms_remaining_next == '0);
        end else begin
          done_reg_next = (target_reg_next != LVL_COLD) && (item.level == target_reg_next);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_cmd     <= CMD_OFF;
      ms_remaining    <= '0;
      pour_started_at <= '0;
      pouring         <= 1'b0;
      pump_reg        <= 1'b0;
      target_reg      <= LVL_COLD;
      done_reg        <= 1'b0;
    end else if (fire) begin
      current_cmd     <= current_cmd_next;
      ms_remaining    <= ms_remaining_next;
      pour_started_at <= pour_started_at_next;
      pouring         <= pouring_next;
      pump_reg        <= pump_reg_next;
      target_reg      <= target_reg_next;
      done_reg        <= done_reg_next;
    end
  end

  // Result register shows the state after the request.
  always_ff @(posedge clk) begin
    if (fire) begin
      res_accepted <= (item.kind != KIND_NONE);
      res_pump     <= pump_reg_next;
      res_target   <= target_reg_next;
      res_done     <= done_reg_next;
      res_ms       <= ms_remaining_next;
      res_cmd      <= current_cmd_next;
    end
  end

endmodule

// File: rtl/brew_command_sequencer.sv
// Requests pass from the classifying front end through a two-entry queue,
// which absorbs output stalls, to the sequencing back end and its result
// register. Throughput: one request per cycle while the queue is not full.
// Reset (synchronous, active high) sets the command to off, clears the brew
// time, the pump, boiler target and done registers, and empties the queue.
module brew_command_sequencer import bcs_pkg::*; #(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [3:0]  cmd_code,
  input  logic [15:0] brew_seconds,
  input  logic [1:0]  switch_pos,
  input  logic        switch_moved,
  input  logic [1:0]  boiler_level,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic        pump_drive,
  output logic [1:0]  boiler_target,
  output logic        done_flag,
  output logic [25:0] brew_ms_left,
  output logic [3:0]  active_cmd
);

  localparam int QW = $bits(item_t) + TIME_BITS;

  item_t                front_item;
  logic [TIME_BITS-1:0] front_now;
  item_t                back_item;
  logic [TIME_BITS-1:0] back_now;
  logic [QW-1:0]        q_head;
  logic                 q_full;
  logic                 q_empty;
  logic                 push;
  logic                 fire;

  bcs_front #(.TIME_BITS(TIME_BITS)) u_front (
    .req_type     (req_type),
    .cmd_code     (cmd_code),
    .brew_seconds (brew_seconds),
    .switch_pos   (switch_pos),
    .switch_moved (switch_moved),
    .boiler_level (boiler_level),
    .now_ms       (now_ms),
    .item         (front_item),
    .now_t        (front_now)
  );

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  // The back end moves on when the result register is free or being taken.
  assign fire     = !q_empty && (!out_valid || !out_stall);

  bcs_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({front_item, front_now}),
    .pop       (fire),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign {back_item, back_now} = q_head;

  bcs_back #(.TIME_BITS(TIME_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .item         (back_item),
    .now_t        (back_now),
    .res_accepted (accepted),
    .res_pump     (pump_drive),
    .res_target   (boiler_target),
    .res_done     (done_flag),
    .res_ms       (brew_ms_left),
    .res_cmd      (active_cmd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/bcs_checker.sv
`include "assert_macros.svh"

module bcs_checker import bcs_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        accepted,
  input logic [25:0] brew_ms_left,
  input logic [3:0]  active_cmd
);

  logic [30:0] res_word;

  assign res_word = {accepted, brew_ms_left, active_cmd};

  `ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid)
  `ASSERT_CLK(a_stall_holds, clk, rst, out_valid && out_stall |=> out_valid && $stable(res_word))
  `ASSERT_CLK(a_ms_bound, clk, rst, out_valid |-> brew_ms_left <= MS_LEFT_MAX)
  `ASSERT_CLK(a_cmd_bound, clk, rst, out_valid |-> active_cmd <= CMD_SW_POUR)

endmodule

bind brew_command_sequencer bcs_checker u_bcs_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .accepted     (accepted),
  .brew_ms_left (brew_ms_left),
  .active_cmd   (active_cmd)
);
